### design/bptg_pkg.sv
// ----------------------------------------------------------------------------
// bptg_pkg
// Shared types and constants of the bounding-box planar texture coordinate
// generator.
// ----------------------------------------------------------------------------
package bptg_pkg;

  localparam int COORD_W = 32;
  localparam int SIZE_W  = 31;
  localparam int DIFF_W  = 33;
  localparam int QUOT_W  = 32;
  localparam int IDX_W   = 3;

  // Magnitude stage, setup stage, one stage per quotient bit, saturation stage.
  localparam int DIV_LAT = QUOT_W + 3;

  localparam logic [IDX_W-1:0] REG_MIN_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_Z  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SIZE_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_SIZE_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_SIZE_Z = 3'd5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 31'd65536;

  localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef logic [1:0] axis_t;

  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff_s;
    logic [SIZE_W-1:0]        size_s;
    logic signed [DIFF_W-1:0] diff_t;
    logic [SIZE_W-1:0]        size_t;
    logic                     last;
  } entry_t;

endpackage

### design/bptg_front.sv
// ----------------------------------------------------------------------------
// bptg_front
// Holds the box registers, ranks the box sizes, picks the s and t axes and
// forms the offsets of each vertex from the box minimum.
// ----------------------------------------------------------------------------
module bptg_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bptg_pkg::IDX_W-1:0]            cfg_index,
  input  logic [bptg_pkg::COORD_W-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [bptg_pkg::COORD_W-1:0]   vertex_x,
  input  logic signed [bptg_pkg::COORD_W-1:0]   vertex_y,
  input  logic signed [bptg_pkg::COORD_W-1:0]   vertex_z,
  input  logic                                  last_vertex,
  output logic                                  ent_valid,
  input  logic                                  ent_ready,
  output bptg_pkg::entry_t                      ent
);

  logic signed [bptg_pkg::COORD_W-1:0] min_x, min_y, min_z;
  logic [bptg_pkg::SIZE_W-1:0]         size_x, size_y, size_z;

  bptg_pkg::axis_t                     ax_s, ax_t;
  logic signed [bptg_pkg::COORD_W-1:0] v_s, v_t, m_s, m_t;
  logic [bptg_pkg::SIZE_W-1:0]         z_s, z_t;
  bptg_pkg::entry_t                    ent_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x  <= '0;
      min_y  <= '0;
      min_z  <= '0;
      size_x <= bptg_pkg::SIZE_RESET;
      size_y <= bptg_pkg::SIZE_RESET;
      size_z <= bptg_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == bptg_pkg::REG_MIN_X)  min_x  <= cfg_data;
      if (cfg_index == bptg_pkg::REG_MIN_Y)  min_y  <= cfg_data;
      if (cfg_index == bptg_pkg::REG_MIN_Z)  min_z  <= cfg_data;
      if (cfg_index == bptg_pkg::REG_SIZE_X) size_x <= cfg_data[bptg_pkg::SIZE_W-1:0];
      if (cfg_index == bptg_pkg::REG_SIZE_Y) size_y <= cfg_data[bptg_pkg::SIZE_W-1:0];
      if (cfg_index == bptg_pkg::REG_SIZE_Z) size_z <= cfg_data[bptg_pkg::SIZE_W-1:0];
    end
  end

  // Three compare-exchange steps; a pair swaps only on strictly smaller size.
  always_comb begin
    logic [bptg_pkg::SIZE_W-1:0] s0, s1, s2, st;
    bptg_pkg::axis_t             a0, a1, a2, at;
    st = '0;
    at = bptg_pkg::AXIS_X;
    s0 = size_x; a0 = bptg_pkg::AXIS_X;
    s1 = size_y; a1 = bptg_pkg::AXIS_Y;
    s2 = size_z; a2 = bptg_pkg::AXIS_Z;
    if (s0 < s1) begin
      st = s0; s0 = s1; s1 = st;
      at = a0; a0 = a1; a1 = at;
    end
    if (s1 < s2) begin
      st = s1; s1 = s2; s2 = st;
      at = a1; a1 = a2; a2 = at;
    end
    if (s0 < s1) begin
      st = s0; s0 = s1; s1 = st;
      at = a0; a0 = a1; a1 = at;
    end
    ax_s = a0;
    ax_t = a1;
  end

  always_comb begin
    unique case (ax_s)
      bptg_pkg::AXIS_Y: begin v_s = vertex_y; m_s = min_y; z_s = size_y; end
      bptg_pkg::AXIS_Z: begin v_s = vertex_z; m_s = min_z; z_s = size_z; end
      default:          begin v_s = vertex_x; m_s = min_x; z_s = size_x; end
    endcase
    unique case (ax_t)
      bptg_pkg::AXIS_Y: begin v_t = vertex_y; m_t = min_y; z_t = size_y; end
      bptg_pkg::AXIS_Z: begin v_t = vertex_z; m_t = min_z; z_t = size_z; end
      default:          begin v_t = vertex_x; m_t = min_x; z_t = size_x; end
    endcase
  end

  always_comb begin
    ent_next.diff_s = {v_s[bptg_pkg::COORD_W-1], v_s} - {m_s[bptg_pkg::COORD_W-1], m_s};
    ent_next.size_s = z_s;
    ent_next.diff_t = {v_t[bptg_pkg::COORD_W-1], v_t} - {m_t[bptg_pkg::COORD_W-1], m_t};
    ent_next.size_t = z_t;
    ent_next.last   = last_vertex;
  end

  assign in_ready = !ent_valid || ent_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (in_ready) begin
      ent_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ent <= ent_next;
    end
  end

endmodule

### design/bptg_fifo.sv
// ----------------------------------------------------------------------------
// bptg_fifo
// Short queue of classified beats between the front and the divider back end.
// ----------------------------------------------------------------------------
module bptg_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  bptg_pkg::entry_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output bptg_pkg::entry_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bptg_pkg::entry_t store [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    cnt;
  logic             push, pop;

  assign push_ready = cnt != CW'(DEPTH);
  assign pop_valid  = cnt != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("queue count above depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> cnt == $past(cnt) + 1'b1)
    else $error("queue count did not grow on push");

  a_cnt_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> cnt == $past(cnt) - 1'b1)
    else $error("queue count did not shrink on pop");

endmodule

### design/bptg_div.sv
// ----------------------------------------------------------------------------
// bptg_div
// Pipelined restoring divider for one coordinate: (diff * 65536) / size,
// truncated toward zero and saturated to signed Q16.16.
// ----------------------------------------------------------------------------
module bptg_div (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [bptg_pkg::DIFF_W-1:0]   diff,
  input  logic [bptg_pkg::SIZE_W-1:0]          size,
  output logic signed [bptg_pkg::COORD_W-1:0]  coord,
  output logic                                 zero_flag
);

  localparam int N = bptg_pkg::QUOT_W;

  logic [bptg_pkg::DIFF_W-1:0] mag0;
  logic [bptg_pkg::SIZE_W-1:0] size0;
  logic                        neg0, dz0;

  logic [bptg_pkg::SIZE_W-1:0] rem  [N+1];
  logic [N-1:0]                work [N+1];
  logic [bptg_pkg::SIZE_W-1:0] sz   [N+1];
  logic                        neg  [N+1];
  logic                        dz   [N+1];
  logic                        zr   [N+1];
  logic                        ovf  [N+1];

  logic signed [bptg_pkg::COORD_W-1:0] coord_next;

  always_ff @(posedge clk) begin
    if (en) begin
      neg0  <= diff[bptg_pkg::DIFF_W-1];
      dz0   <= diff == '0;
      mag0  <= diff[bptg_pkg::DIFF_W-1] ? bptg_pkg::DIFF_W'(-diff) : diff;
      size0 <= size;
    end
  end

  // The quotient fits in 32 bits unless mag >= size * 65536.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {14'd0, mag0[32:16]};
      work[0] <= {mag0[15:0], 16'd0};
      sz[0]   <= size0;
      neg[0]  <= neg0;
      dz[0]   <= dz0;
      zr[0]   <= size0 == '0;
      ovf[0]  <= (size0 != '0) && ({16'd0, mag0} >= {2'd0, size0, 16'd0});
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [bptg_pkg::SIZE_W:0] trial;
    logic [bptg_pkg::SIZE_W:0] diffr;
    logic                      ge;

    assign trial = {rem[k], work[k][N-1]};
    assign diffr = trial - {1'b0, sz[k]};
    assign ge    = trial >= {1'b0, sz[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? diffr[bptg_pkg::SIZE_W-1:0] : trial[bptg_pkg::SIZE_W-1:0];
        work[k+1] <= {work[k][N-2:0], ge};
        sz[k+1]   <= sz[k];
        neg[k+1]  <= neg[k];
        dz[k+1]   <= dz[k];
        zr[k+1]   <= zr[k];
        ovf[k+1]  <= ovf[k];
      end
    end
  end

  always_comb begin
    priority if (zr[N]) begin
      coord_next = dz[N] ? '0 : (neg[N] ? bptg_pkg::Q_MIN : bptg_pkg::Q_MAX);
    end else if (ovf[N]) begin
      coord_next = neg[N] ? bptg_pkg::Q_MIN : bptg_pkg::Q_MAX;
    end else if (neg[N]) begin
      coord_next = (work[N] > 32'h8000_0000) ? bptg_pkg::Q_MIN : -$signed(work[N]);
    end else begin
      coord_next = work[N][N-1] ? bptg_pkg::Q_MAX : $signed(work[N]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord     <= coord_next;
      zero_flag <= zr[N];
    end
  end

endmodule

### design/bptg_back.sv
// ----------------------------------------------------------------------------
// bptg_back
// Runs the s and t divisions side by side and tracks beat valid and the
// last-vertex mark along the divider pipeline.
// ----------------------------------------------------------------------------
module bptg_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 ent_valid,
  output logic                                 ent_ready,
  input  bptg_pkg::entry_t                     ent,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bptg_pkg::COORD_W-1:0]  coord_s,
  output logic signed [bptg_pkg::COORD_W-1:0]  coord_t,
  output logic                                 zero_extent,
  output logic                                 last_coord
);

  localparam int L = bptg_pkg::DIV_LAT;

  logic         adv;
  logic [L-1:0] vld;
  logic [L-1:0] lst;
  logic         zero_s, zero_t;

  assign adv       = !out_valid || out_ready;
  assign ent_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], ent_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lst <= {lst[L-2:0], ent.last};
    end
  end

  bptg_div u_div_s (
    .clk       (clk),
    .en        (adv),
    .diff      (ent.diff_s),
    .size      (ent.size_s),
    .coord     (coord_s),
    .zero_flag (zero_s)
  );

  bptg_div u_div_t (
    .clk       (clk),
    .en        (adv),
    .diff      (ent.diff_t),
    .size      (ent.size_t),
    .coord     (coord_t),
    .zero_flag (zero_t)
  );

  assign out_valid   = vld[L-1];
  assign last_coord  = lst[L-1];
  assign zero_extent = zero_s || zero_t;

endmodule

### design/bbox_planar_texcoord_gen.sv
// ----------------------------------------------------------------------------
// bbox_planar_texcoord_gen
// Default planar texture coordinates of vertices from a configured bounding
// box, in signed Q16.16.
// ----------------------------------------------------------------------------
// The block takes one vertex beat per clock while in_ready is high and returns
// one coordinate beat per vertex, in order. A beat passes through the
// axis-selection register, the queue and the divider pipeline: a magnitude
// stage, a setup stage, 32 quotient stages of restoring division and a
// saturation stage. The box registers are written through the plain write
// port and must only change while no vertex is in flight.
module bbox_planar_texcoord_gen #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bptg_pkg::IDX_W-1:0]           cfg_index,
  input  logic [bptg_pkg::COORD_W-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [bptg_pkg::COORD_W-1:0]  vertex_x,
  input  logic signed [bptg_pkg::COORD_W-1:0]  vertex_y,
  input  logic signed [bptg_pkg::COORD_W-1:0]  vertex_z,
  input  logic                                 last_vertex,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bptg_pkg::COORD_W-1:0]  coord_s,
  output logic signed [bptg_pkg::COORD_W-1:0]  coord_t,
  output logic                                 zero_extent,
  output logic                                 last_coord
);

  logic             f_valid, f_ready;
  bptg_pkg::entry_t f_ent;
  logic             q_valid, q_ready;
  bptg_pkg::entry_t q_ent;

  bptg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .vertex_z    (vertex_z),
    .last_vertex (last_vertex),
    .ent_valid   (f_valid),
    .ent_ready   (f_ready),
    .ent         (f_ent)
  );

  bptg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_ent),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_ent)
  );

  bptg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .ent_valid   (q_valid),
    .ent_ready   (q_ready),
    .ent         (q_ent),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .coord_s     (coord_s),
    .coord_t     (coord_t),
    .zero_extent (zero_extent),
    .last_coord  (last_coord)
  );

  a_no_out_after_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat presented right after reset");

endmodule
